// ===== rtl/bba_pkg.sv =====
// Package for the bitmap block allocator: sizes, request and response types,
// command, status and state codes. Used by bitmap_block_allocator_unit.
package bba_pkg;

  // Bitmap geometry (word size is a power of two, a multiple of 8 bits)
  localparam int WORDS     = 64;
  localparam int WORD_BITS = 64;
  localparam int NUM_W     = 16;
  localparam int CAP       = WORDS * WORD_BITS;

  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CUR_W     = $clog2(WORDS + 1);
  localparam int CNT_W     = $clog2(CAP + 1);

  // Free-bit search works on groups of 8 bits
  localparam int GRP_BITS  = 8;
  localparam int GRPS      = WORD_BITS / GRP_BITS;
  localparam int GRP_W     = (GRPS > 1) ? $clog2(GRPS) : 1;
  localparam int GIDX_W    = $clog2(GRP_BITS);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = CFG_IDX_W'(1);
  localparam logic [NUM_W-1:0]     RST_RANGE_LOW  = NUM_W'(0);
  localparam logic [NUM_W-1:0]     RST_RANGE_HIGH = NUM_W'(4095);

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FIND  = 2'd3
  } bba_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } bba_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FCHK,
    S_FPICK
  } bba_state_t;

  typedef struct packed {
    bba_cmd_t           command;
    logic [NUM_W-1:0]   bit_number;
  } bba_req_t;

  typedef struct packed {
    logic               bit_value;
    logic [NUM_W-1:0]   free_number;
    bba_status_t        status;
  } bba_rsp_t;

endpackage

// ===== rtl/bitmap_block_allocator_unit.sv =====
// Bitmap block allocator: 64 x 64-bit used-bit memory with a word cursor.
// Depends on bba_pkg for sizes, codes and the request/response structs.
// Get, set, clear: memory read when the request is taken, then modify/write and result.
// Find: reads words from the cursor, skipping full words (up to WORDS), until a free number
//   turns up and is picked; reports full when the search runs off the end.
// Result sits in an output register; a stalled result holds the next finish.
// Reset (synchronous, rst_n low): bitmap reads as all free via per-word valid bits,
//   cursor 0, range 0..4095; no clearing pass.
module bitmap_block_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bba_pkg::bba_req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bba_pkg::bba_rsp_t                 out_data,
  input  logic                              cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bba_pkg::NUM_W-1:0]         cfg_data
);
  import bba_pkg::*;

  // Configuration and derived range values
  logic [NUM_W-1:0]     low_r, high_r, low_nxt, high_nxt, src_low, src_high;
  logic                 cfg_hit;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CUR_W-1:0]     len_r, len_nxt;
  logic [ADDR_W-1:0]    last_r, last_nxt;
  logic [WORD_BITS-1:0] pad_r, pad_nxt;
  logic [NUM_W:0]       span;
  logic [CNT_W:0]       len_sum;
  logic [BIT_W-1:0]     rem;

  // Control and request state
  bba_state_t           state_r, state_nxt;
  bba_cmd_t             cmd_r;
  logic [BIT_W-1:0]     bit_r;
  logic [ADDR_W-1:0]    idx_r;
  bba_status_t          flag_r, flag_nxt;
  logic [CUR_W-1:0]     cursor_r, cursor_nxt, cur_inc;
  logic                 take_req;

  // Request decode
  logic [NUM_W:0]       off;
  logic                 req_oor;
  logic [ADDR_W-1:0]    req_idx;
  logic [BIT_W-1:0]     req_bit;

  // Memory
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     vld_r;
  logic [WORD_BITS-1:0] rdata_r, mem_wdata, word, word_m, bit_mask;
  logic                 vld_q_r, mem_re, mem_we;
  logic [ADDR_W-1:0]    mem_raddr;

  // Free-bit search
  logic [WORD_BITS-1:0] w_r, w_nxt;
  logic [GRPS-1:0]      gfull_r, gfull_nxt;
  logic [GRP_W-1:0]     sel_grp;
  logic [GIDX_W-1:0]    sel_bit;
  logic [GRP_BITS-1:0]  grp_bits;
  logic [BIT_W-1:0]     pick_bit;

  // Output register
  bba_rsp_t             out_r, rsp_nxt;
  logic                 out_valid_r, out_free, out_load;

  // Apply configuration writes; derived values follow the new settings
  assign cfg_hit  = cfg_we && (cfg_index == CFG_RANGE_LOW || cfg_index == CFG_RANGE_HIGH);
  assign low_nxt  = (cfg_we && cfg_index == CFG_RANGE_LOW)  ? cfg_data : low_r;
  assign high_nxt = (cfg_we && cfg_index == CFG_RANGE_HIGH) ? cfg_data : high_r;
  assign src_low  = rst_n ? low_nxt  : RST_RANGE_LOW;
  assign src_high = rst_n ? high_nxt : RST_RANGE_HIGH;

  always_comb begin
    span = {1'b0, src_high} - {1'b0, src_low} + (NUM_W+1)'(1);
    if (src_high < src_low) begin
      cnt_nxt = '0;
    end else if (span > (NUM_W+1)'(CAP)) begin
      cnt_nxt = CNT_W'(CAP);
    end else begin
      cnt_nxt = span[CNT_W-1:0];
    end
    len_sum  = {1'b0, cnt_nxt} + (CNT_W+1)'(WORD_BITS - 1);
    len_nxt  = CUR_W'(len_sum >> BIT_W);
    last_nxt = ADDR_W'(len_nxt - CUR_W'(1));
    rem      = cnt_nxt[BIT_W-1:0];
    for (int b = 0; b < WORD_BITS; b++) begin
      pad_nxt[b] = (rem != '0) && (BIT_W'(b) >= rem);
    end
  end

  // Decode the incoming request against the range
  always_comb begin
    off     = {1'b0, in_data.bit_number} - {1'b0, low_r};
    req_oor = off[NUM_W] || (off[NUM_W-1:0] >= NUM_W'(cnt_r));
    req_idx = off[BIT_W+ADDR_W-1:BIT_W];
    req_bit = off[BIT_W-1:0];
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cur_inc  = cursor_r + CUR_W'(1);

  // Word as read; never-written words read as free
  assign word = vld_q_r ? rdata_r : '0;

  always_comb begin
    word_m = word;
    if (cursor_r[ADDR_W-1:0] == last_r) begin
      word_m = word | pad_r;
    end
    bit_mask = '0;
    bit_mask[bit_r] = 1'b1;
  end

  // Pick the lowest zero bit of the held word
  always_comb begin
    sel_grp = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (!gfull_r[g]) begin
        sel_grp = GRP_W'(g);
      end
    end
    grp_bits = w_r[sel_grp * GRP_BITS +: GRP_BITS];
    sel_bit  = '0;
    for (int b = GRP_BITS - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        sel_bit = GIDX_W'(b);
      end
    end
    pick_bit = BIT_W'(int'(sel_grp) * GRP_BITS + int'(sel_bit));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_FIND && cursor_r < len_r) begin
            state_nxt = S_FCHK;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FCHK: begin
        if (&word_m) begin
          if (cur_inc >= len_r) begin
            state_nxt = S_EXEC;
          end
        end else begin
          state_nxt = S_FPICK;
        end
      end
      S_FPICK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control per state
  always_comb begin
    take_req   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = cursor_r[ADDR_W-1:0];
    mem_we     = 1'b0;
    mem_wdata  = word;
    out_load   = 1'b0;
    rsp_nxt    = '0;
    cursor_nxt = cursor_r;
    flag_nxt   = flag_r;
    w_nxt      = w_r;
    gfull_nxt  = gfull_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          take_req = 1'b1;
          mem_re   = 1'b1;
          if (in_data.command == CMD_FIND) begin
            flag_nxt = (cursor_r >= len_r) ? ST_FULL : ST_OK;
          end else begin
            mem_raddr = req_idx;
            flag_nxt  = req_oor ? ST_RANGE : ST_OK;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          case (flag_r)
            ST_RANGE: rsp_nxt.status = ST_RANGE;
            ST_FULL:  rsp_nxt.status = ST_FULL;
            default: begin
              case (cmd_r)
                CMD_GET: rsp_nxt.bit_value = word[bit_r];
                CMD_SET: begin
                  mem_we    = 1'b1;
                  mem_wdata = word | bit_mask;
                end
                CMD_CLEAR: begin
                  mem_we    = 1'b1;
                  mem_wdata = word & ~bit_mask;
                  if (cursor_r > CUR_W'(idx_r)) begin
                    cursor_nxt = CUR_W'(idx_r);
                  end
                end
                default: ;
              endcase
            end
          endcase
        end
      end
      S_FCHK: begin
        if (&word_m) begin
          // Skip the full word and advance the cursor
          cursor_nxt = cur_inc;
          if (cur_inc >= len_r) begin
            flag_nxt = ST_FULL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cur_inc[ADDR_W-1:0];
          end
        end else begin
          w_nxt = word_m;
          for (int g = 0; g < GRPS; g++) begin
            gfull_nxt[g] = &word_m[g * GRP_BITS +: GRP_BITS];
          end
        end
      end
      S_FPICK: begin
        if (out_free) begin
          out_load            = 1'b1;
          rsp_nxt.free_number = low_r + NUM_W'({cursor_r[ADDR_W-1:0], pick_bit});
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= RST_RANGE_LOW;
      high_r      <= RST_RANGE_HIGH;
      cursor_r    <= '0;
      flag_r      <= ST_OK;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      cursor_r <= cfg_hit ? '0 : cursor_nxt;
      flag_r   <= flag_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Payload and derived registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
    pad_r   <= pad_nxt;
    w_r     <= w_nxt;
    gfull_r <= gfull_nxt;
    if (take_req) begin
      cmd_r <= in_data.command;
      bit_r <= req_bit;
      idx_r <= req_idx;
    end
    if (out_load) begin
      out_r <= rsp_nxt;
    end
  end

  // Bitmap memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
      vld_q_r <= vld_r[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Cursor never passes the end of the used words
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= len_r)
    else $error("cursor beyond used words");

  // Scanning only happens on words inside the range
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCHK) |-> (cursor_r < len_r))
    else $error("scan outside used words");

  // Memory writes come only from an in-range set or clear
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC && flag_r == ST_OK &&
                (cmd_r == CMD_SET || cmd_r == CMD_CLEAR)))
    else $error("unexpected bitmap write");

  // The pick stage always holds a word with a free bit
  a_pick_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FPICK) |-> !(&w_r))
    else $error("pick on a full word");

  // An accepted request leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted but block idle");

endmodule
